// ===== design/mrs_pkg.sv =====
package mrs_pkg;

  localparam int MAX_COARSE_WIDTH  = 512;
  localparam int MAX_COARSE_HEIGHT = 4096;
  localparam int SAMPLE_WIDTH      = 32;

  localparam int CW_W  = 10;
  localparam int CH_W  = 13;
  localparam int CFG_W = 13;
  localparam int IDX_W = 2;

  localparam int COL_W = $clog2(2 * MAX_COARSE_WIDTH);
  localparam int ROW_W = $clog2(2 * MAX_COARSE_HEIGHT);
  localparam int IC_W  = $clog2(MAX_COARSE_WIDTH);
  localparam int JC_W  = $clog2(MAX_COARSE_HEIGHT);

  typedef enum logic [IDX_W-1:0] {
    CFG_COARSE_WIDTH  = 2'd0,
    CFG_COARSE_HEIGHT = 2'd1,
    CFG_REDUCE_MODE   = 2'd2
  } cfg_idx_t;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    sample_t           hv;
    logic [IC_W-1:0]   ic;
    logic [JC_W-1:0]   jc;
    logic              row_even;
    logic              row_first;
    logic              row_last;
    logic              last;
  } vert_t;

  // mode 0: maximum, mode 1: minimum
  function automatic sample_t pick(input logic mode, input sample_t a, input sample_t b);
    sample_t r;
    if (mode) begin
      r = (a <= b) ? a : b;
    end else begin
      r = (a >= b) ? a : b;
    end
    return r;
  endfunction

endpackage

// ===== design/mrs_ram.sv =====
module mrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/monotone_restrict_3x3_stride2_unit.sv =====
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  fine_sample, start_of_frame
// out_     output     out_valid/out_stall coarse_value, coarse_x, coarse_y, last_of_frame
// cfg_     input      cfg_we             cfg_index, cfg_data
//
// One item per cycle while in_stall is low. An item that completes its window yields
// a result through the input compare stage with line buffer read, then the output register.
// Line buffer RAMs have a registered read, so read data arrives with the vertical stage.
// Sync active-low reset: register defaults; counters, partials, valids cleared.
// in_stall rises only while both stages are full and out_stall is high.
module monotone_restrict_3x3_stride2_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            in_fine_sample,
  input  logic                          in_start_of_frame,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_coarse_value,
  output logic [8:0]                    out_coarse_x,
  output logic [11:0]                   out_coarse_y,
  output logic                          out_last_of_frame,
  input  logic                          cfg_we,
  input  logic [mrs_pkg::IDX_W-1:0]     cfg_index,
  input  logic [mrs_pkg::CFG_W-1:0]     cfg_data
);

  logic [mrs_pkg::CW_W-1:0]  cw_r;
  logic [mrs_pkg::CH_W-1:0]  ch_r;
  logic                      mode_r;

  logic [mrs_pkg::CW_W-1:0]  w_cl;
  logic [mrs_pkg::CH_W-1:0]  h_cl;
  logic [mrs_pkg::COL_W-1:0] fw;
  logic [mrs_pkg::ROW_W-1:0] fh;

  logic [mrs_pkg::COL_W-1:0] col_r, col_nxt, col_cur;
  logic [mrs_pkg::ROW_W-1:0] row_r, row_nxt, row_cur;
  mrs_pkg::sample_t          hp_r, hp_nxt;
  mrs_pkg::sample_t          scp_r, scp_nxt;

  logic                      in_acc;
  logic                      have_h;
  mrs_pkg::vert_t            v0;
  mrs_pkg::vert_t            s1_r;
  logic                      s1_valid_r, s1_valid_nxt;
  logic                      s1_adv, s1_go, s1_emit;
  mrs_pkg::sample_t          s1_v;

  mrs_pkg::sample_t          band_rd, sra_rd;

  logic                      out_valid_r, out_valid_nxt;
  mrs_pkg::sample_t          out_value_r;
  logic [mrs_pkg::IC_W-1:0]  out_x_r;
  logic [mrs_pkg::JC_W-1:0]  out_y_r;
  logic                      out_last_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r   <= mrs_pkg::CW_W'(2);
      ch_r   <= mrs_pkg::CH_W'(2);
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mrs_pkg::CFG_COARSE_WIDTH:  cw_r   <= cfg_data[mrs_pkg::CW_W-1:0];
        mrs_pkg::CFG_COARSE_HEIGHT: ch_r   <= cfg_data[mrs_pkg::CH_W-1:0];
        mrs_pkg::CFG_REDUCE_MODE:   mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cw_r < mrs_pkg::CW_W'(2)) begin
      w_cl = mrs_pkg::CW_W'(2);
    end else if (cw_r > mrs_pkg::CW_W'(mrs_pkg::MAX_COARSE_WIDTH)) begin
      w_cl = mrs_pkg::CW_W'(mrs_pkg::MAX_COARSE_WIDTH);
    end else begin
      w_cl = cw_r;
    end
    if (ch_r < mrs_pkg::CH_W'(2)) begin
      h_cl = mrs_pkg::CH_W'(2);
    end else if (ch_r > mrs_pkg::CH_W'(mrs_pkg::MAX_COARSE_HEIGHT)) begin
      h_cl = mrs_pkg::CH_W'(mrs_pkg::MAX_COARSE_HEIGHT);
    end else begin
      h_cl = ch_r;
    end
    fw = mrs_pkg::COL_W'({w_cl, 1'b0} - 1'b1);
    fh = mrs_pkg::ROW_W'({h_cl, 1'b0} - 1'b1);
  end

  // handshake
  assign s1_adv   = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // position and horizontal pass
  always_comb begin
    col_cur = in_start_of_frame ? '0 : col_r;
    row_cur = in_start_of_frame ? '0 : row_r;
    if (col_cur >= fw) begin
      col_cur = '0;
    end
    if (row_cur >= fh) begin
      row_cur = '0;
    end

    hp_nxt  = hp_r;
    scp_nxt = scp_r;
    have_h  = 1'b0;
    v0      = '0;
    v0.ic   = col_cur[mrs_pkg::IC_W:1];
    v0.jc   = row_cur[mrs_pkg::JC_W:1];
    if (!col_cur[0]) begin
      hp_nxt = (col_cur == '0) ? in_fine_sample
                               : mrs_pkg::pick(mode_r, scp_r, in_fine_sample);
      v0.hv  = hp_nxt;
      have_h = (col_cur == fw - 1'b1);
    end else begin
      v0.hv   = mrs_pkg::pick(mode_r, hp_r, in_fine_sample);
      scp_nxt = in_fine_sample;
      have_h  = 1'b1;
    end
    v0.row_even  = !row_cur[0];
    v0.row_first = (row_cur == '0);
    v0.row_last  = (row_cur == fh - 1'b1);
    v0.last      = (v0.ic == mrs_pkg::IC_W'(w_cl - 1'b1)) &&
                   (v0.jc == mrs_pkg::JC_W'(h_cl - 1'b1));

    if (col_cur == fw - 1'b1) begin
      col_nxt = '0;
      row_nxt = (row_cur == fh - 1'b1) ? '0 : row_cur + 1'b1;
    end else begin
      col_nxt = col_cur + 1'b1;
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      hp_r  <= '0;
      scp_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      hp_r  <= hp_nxt;
      scp_r <= scp_nxt;
    end
  end

  // vertical stage
  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = have_h;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= v0;
    end
  end

  mrs_ram #(
    .WIDTH (mrs_pkg::SAMPLE_WIDTH),
    .DEPTH (mrs_pkg::MAX_COARSE_WIDTH)
  ) u_band (
    .clk   (clk),
    .we    (s1_go && s1_r.row_even),
    .waddr (s1_r.ic),
    .wdata (s1_v),
    .re    (in_acc),
    .raddr (v0.ic),
    .rdata (band_rd)
  );

  mrs_ram #(
    .WIDTH (mrs_pkg::SAMPLE_WIDTH),
    .DEPTH (mrs_pkg::MAX_COARSE_WIDTH)
  ) u_shared (
    .clk   (clk),
    .we    (s1_go && !s1_r.row_even),
    .waddr (s1_r.ic),
    .wdata (s1_r.hv),
    .re    (in_acc),
    .raddr (v0.ic),
    .rdata (sra_rd)
  );

  always_comb begin
    if (s1_r.row_even) begin
      s1_v = s1_r.row_first ? s1_r.hv : mrs_pkg::pick(mode_r, sra_rd, s1_r.hv);
    end else begin
      s1_v = mrs_pkg::pick(mode_r, band_rd, s1_r.hv);
    end
    s1_emit = !s1_r.row_even || s1_r.row_last;
  end

  // output register
  always_comb begin
    if (s1_go && s1_emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      out_value_r <= s1_v;
      out_x_r     <= s1_r.ic;
      out_y_r     <= s1_r.jc;
      out_last_r  <= s1_r.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_coarse_value  = out_value_r;
  assign out_coarse_x      = out_x_r;
  assign out_coarse_y      = out_y_r;
  assign out_last_of_frame = out_last_r;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free stage");

  a_odd_column_reaches_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && col_cur[0]) |=> s1_valid_r)
    else $error("odd column item lost before vertical stage");

  a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_r)))
    else $error("vertical stage changed while blocked");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

typedef struct {
  mrs_pkg::sample_t value;
  logic [8:0]       x;
  logic [11:0]      y;
  logic             last;
} coarse_item_t;

class coarse_grid_calc;
  mrs_pkg::sample_t band [mrs_pkg::MAX_COARSE_WIDTH];
  mrs_pkg::sample_t row_share [mrs_pkg::MAX_COARSE_WIDTH];
  bit               band_set [mrs_pkg::MAX_COARSE_WIDTH];
  bit               row_share_set [mrs_pkg::MAX_COARSE_WIDTH];
  mrs_pkg::sample_t h_part;
  mrs_pkg::sample_t col_share;
  int               fcol;
  int               frow;
  int               width_reg;
  int               height_reg;
  bit               min_mode;
  coarse_item_t     due [$];
  int               mismatches;

  function new();
    h_part = 0;
    col_share = 0;
    fcol = 0;
    frow = 0;
    width_reg = 2;
    height_reg = 2;
    min_mode = 0;
    mismatches = 0;
  endfunction

  function void write_reg(mrs_pkg::cfg_idx_t idx, int data);
    case (idx)
      mrs_pkg::CFG_COARSE_WIDTH: begin
        width_reg = data & 'h3FF;
      end
      mrs_pkg::CFG_COARSE_HEIGHT: begin
        height_reg = data & 'h1FFF;
      end
      mrs_pkg::CFG_REDUCE_MODE: begin
        min_mode = data[0];
      end
      default: ;
    endcase
  endfunction

  function int coarse_cols();
    if (width_reg < 2) return 2;
    if (width_reg > mrs_pkg::MAX_COARSE_WIDTH) return mrs_pkg::MAX_COARSE_WIDTH;
    return width_reg;
  endfunction

  function int coarse_rows();
    if (height_reg < 2) return 2;
    if (height_reg > mrs_pkg::MAX_COARSE_HEIGHT) return mrs_pkg::MAX_COARSE_HEIGHT;
    return height_reg;
  endfunction

  function int fine_cols();
    return 2 * coarse_cols() - 1;
  endfunction

  function int fine_rows();
    return 2 * coarse_rows() - 1;
  endfunction

  function mrs_pkg::sample_t better(mrs_pkg::sample_t a, mrs_pkg::sample_t b);
    if (min_mode) return (a <= b) ? a : b;
    return (a >= b) ? a : b;
  endfunction

  // position after a restart or a stale counter is cleared
  function void locate(bit sof, output int col, output int row);
    col = sof ? 0 : fcol;
    row = sof ? 0 : frow;
    if (col >= fine_cols()) col = 0;
    if (row >= fine_rows()) row = 0;
  endfunction

  function bit reads_unset(bit sof);
    int col;
    int row;
    int ic;
    locate(sof, col, row);
    ic = col / 2;
    if (col % 2 == 0 && col != fine_cols() - 1) return 0;
    if (row % 2 == 1) return !band_set[ic];
    return row != 0 && !row_share_set[ic];
  endfunction

  function void take_fine(mrs_pkg::sample_t x, bit sof);
    int               col;
    int               row;
    int               ic;
    bit               have_h;
    bit               emit;
    mrs_pkg::sample_t hv;
    mrs_pkg::sample_t v;
    coarse_item_t     r;
    locate(sof, col, row);
    ic = col / 2;
    have_h = 1;
    if (col % 2 == 0) begin
      v = (col == 0) ? x : better(col_share, x);
      h_part = v;
      hv = v;
      have_h = (col == fine_cols() - 1);
    end else begin
      hv = better(h_part, x);
      col_share = x;
    end
    if (have_h) begin
      if (row % 2 == 0) begin
        v = (row == 0) ? hv : better(row_share[ic], hv);
        band[ic] = v;
        band_set[ic] = 1;
        emit = (row == fine_rows() - 1);
      end else begin
        v = better(band[ic], hv);
        row_share[ic] = hv;
        row_share_set[ic] = 1;
        emit = 1;
      end
      if (emit) begin
        r.value = v;
        r.x = 9'(ic);
        r.y = 12'(row / 2);
        r.last = (ic == coarse_cols() - 1) && (row / 2 == coarse_rows() - 1);
        due.push_back(r);
      end
    end
    col++;
    if (col >= fine_cols()) begin
      col = 0;
      row++;
      if (row >= fine_rows()) row = 0;
    end
    fcol = col;
    frow = row;
  endfunction

  function void match_coarse(mrs_pkg::sample_t v, logic [8:0] x, logic [11:0] y, logic last);
    coarse_item_t e;
    if (due.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual value %0d x %0d y %0d last %0b",
               $time, v, x, y, last);
      mismatches++;
      return;
    end
    e = due.pop_front();
    if (v !== e.value) begin
      $display("%0t: coarse_value expected %0d actual %0d", $time, e.value, v);
      mismatches++;
    end
    if (x !== e.x) begin
      $display("%0t: coarse_x expected %0d actual %0d", $time, e.x, x);
      mismatches++;
    end
    if (y !== e.y) begin
      $display("%0t: coarse_y expected %0d actual %0d", $time, e.y, y);
      mismatches++;
    end
    if (last !== e.last) begin
      $display("%0t: last_of_frame expected %0b actual %0b", $time, e.last, last);
      mismatches++;
    end
  endfunction

  function int pending();
    return due.size();
  endfunction
endclass

module tb;
  localparam int QUIET_LIMIT = 2000;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  mrs_pkg::sample_t            in_fine_sample = '0;
  logic                        in_start_of_frame = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  mrs_pkg::sample_t            out_coarse_value;
  logic [8:0]                  out_coarse_x;
  logic [11:0]                 out_coarse_y;
  logic                        out_last_of_frame;
  logic                        cfg_we = 1'b0;
  mrs_pkg::cfg_idx_t           cfg_index = mrs_pkg::CFG_COARSE_WIDTH;
  logic [mrs_pkg::CFG_W-1:0]   cfg_data = '0;

  coarse_grid_calc grid;
  int              quiet = 0;
  int              hold_cycles = 0;
  bit              stall_bursts = 1;
  bit              sender_idles = 0;

  monotone_restrict_3x3_stride2_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_fine_sample    (in_fine_sample),
    .in_start_of_frame (in_start_of_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_coarse_value  (out_coarse_value),
    .out_coarse_x      (out_coarse_x),
    .out_coarse_y      (out_coarse_y),
    .out_last_of_frame (out_last_of_frame),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      grid.match_coarse(out_coarse_value, out_coarse_x, out_coarse_y, out_last_of_frame);
    end
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("monotone_restrict_3x3_stride2_unit regression: fail");
      $finish;
    end
  end

  always begin : rx_side
    @(posedge clk);
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      repeat (hold_cycles) @(posedge clk);
      hold_cycles = 0;
      out_stall <= 1'b0;
    end else if (stall_bursts && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  function automatic mrs_pkg::sample_t rand_sample();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1, 2: return mrs_pkg::sample_t'(int'($urandom_range(0, 6)) - 3);
      default: return $urandom;
    endcase
  endfunction

  // a start is forced where the item would read a line buffer entry never written
  task automatic offer(mrs_pkg::sample_t x, bit sof);
    bit f;
    f = sof || grid.reads_unset(sof);
    if (sender_idles && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_fine_sample <= x;
    in_start_of_frame <= f;
    do @(posedge clk); while (in_stall !== 1'b0);
    grid.take_fine(x, f);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (grid.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic configure(int w, int h, int m);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= mrs_pkg::CFG_COARSE_WIDTH;
    cfg_data <= 13'(w);
    @(posedge clk);
    cfg_index <= mrs_pkg::CFG_COARSE_HEIGHT;
    cfg_data <= 13'(h);
    @(posedge clk);
    cfg_index <= mrs_pkg::CFG_REDUCE_MODE;
    cfg_data <= 13'(m);
    @(posedge clk);
    cfg_we <= 1'b0;
    grid.write_reg(mrs_pkg::CFG_COARSE_WIDTH, w);
    grid.write_reg(mrs_pkg::CFG_COARSE_HEIGHT, h);
    grid.write_reg(mrs_pkg::CFG_REDUCE_MODE, m);
  endtask

  // frames in raster order; noise gives roughly one stray start per that many items
  task automatic send_frames(int count, int noise);
    bit sof;
    for (int i = 0; i < count; i++) begin
      if (grid.fcol == 0 && grid.frow == 0) begin
        sof = $urandom_range(0, 7) != 0;
      end else begin
        sof = noise != 0 && $urandom_range(0, noise) == 0;
      end
      offer(rand_sample(), sof);
    end
  endtask

  initial begin
    mrs_pkg::sample_t corner_vals [9];
    int               w;
    int               h;
    grid = new();
    corner_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 0, -1, 1, 32'h8000_0000,
                    32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 2x2 coarse grid, maximum
    for (int i = 0; i < 9; i++) offer(corner_vals[i], i == 0);
    configure(2, 2, 1);
    for (int i = 0; i < 9; i++) offer(corner_vals[8 - i], i == 0);
    // restart part way through a frame
    for (int i = 0; i < 5; i++) offer(corner_vals[i], i == 0 || i == 3);

    sender_idles = 1;
    configure(0, 1, 0);
    send_frames(30, 0);
    // widest grid: first part of a long fine row
    configure(8191, 2, $urandom_range(0, 8191));
    send_frames(120, 0);
    // wide grid: at least one full fine row, then part of another
    configure($urandom_range(40, 90), 2, $urandom_range(0, 8191));
    send_frames(260, 0);
    // tallest grid, entered from a stale position
    configure(2, 8191, $urandom_range(0, 8191));
    send_frames(80, 0);

    for (int p = 0; p < 8; p++) begin
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9);
      h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
      sender_idles = $urandom_range(0, 3) != 0;
      configure(w, h, $urandom_range(0, 8191));
      send_frames(20, (p % 3 == 0) ? 25 : 0);
      if ($urandom_range(0, 2) == 0) drain_results();
      send_frames(20, (p % 3 == 0) ? 25 : 0);
    end

    // long receiver hold while items keep coming
    sender_idles = 0;
    configure(2, $urandom_range(2, 4), $urandom_range(0, 1));
    hold_cycles = 250;
    send_frames(120, 0);

    // no idling to the end
    stall_bursts = 0;
    configure($urandom_range(2, 7), $urandom_range(2, 5), $urandom_range(0, 1));
    send_frames(200, 40);

    drain_results();
    if (grid.mismatches == 0) begin
      $display("monotone_restrict_3x3_stride2_unit regression: pass");
    end else begin
      $display("monotone_restrict_3x3_stride2_unit regression: fail");
    end
    $finish;
  end
endmodule
